>>> hdl/interval_profiler_stats_assert.svh
// Assertion macros for the interval profiler statistics block.
`ifndef INTERVAL_PROFILER_STATS_ASSERT_SVH
`define INTERVAL_PROFILER_STATS_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define IPS_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ips assertion failed");

// Next-cycle implication, disabled while reset is high.
`define IPS_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ips assertion failed");

// Next-cycle implication that also holds across reset.
`define IPS_ASSERT_RST(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("ips assertion failed");

`endif

>>> hdl/ips_pkg.sv
package ips_pkg;

   localparam int SLOTS      = 16;
   localparam int SLOT_BITS  = $clog2(SLOTS);
   localparam int SLOT_FIELD = 4;
   localparam int LINE_BITS  = 24;
   localparam int SUM_BITS   = 40;
   localparam int TALLY_BITS = 32;

   typedef struct packed {
      logic [LINE_BITS-1:0]  line_count;
      logic [SLOT_FIELD-1:0] slot;
   } ips_request_type;

   localparam int REQ_BITS  = $bits(ips_request_type);
   localparam int REQ_BYTES = (REQ_BITS + 7) / 8;

   // last field in the lowest bits
   typedef struct packed {
      logic [TALLY_BITS-1:0] samples;
      logic [SUM_BITS-1:0]   total_lines;
      logic [LINE_BITS-1:0]  max_lines;
      logic [LINE_BITS-1:0]  min_lines;
      logic [LINE_BITS-1:0]  interval;
      logic                  now_active;
   } ips_result_type;

   localparam int RSP_BITS  = $bits(ips_result_type);
   localparam int RSP_BYTES = (RSP_BITS + 7) / 8;

   typedef struct packed {
      logic                  running;
      logic [LINE_BITS-1:0]  start_mark;
      logic [LINE_BITS-1:0]  least;
      logic [LINE_BITS-1:0]  greatest;
      logic [SUM_BITS-1:0]   accumulated;
      logic [TALLY_BITS-1:0] tally;
   } ips_row_type;

   localparam int ROW_BITS = $bits(ips_row_type);

   // value of a slot that has never been written; start mark is don't-care
   localparam ips_row_type RESET_ROW = '{
      running:     1'b0,
      start_mark:  '0,
      least:       '1,
      greatest:    '0,
      accumulated: '0,
      tally:       '0
   };

endpackage

>>> hdl/ips_ram.sv
module ips_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read before write on a shared address
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/ips_update.sv
module ips_update
   import ips_pkg::*;
(
   input  ips_row_type          row,
   input  logic [LINE_BITS-1:0] line_count,
   output ips_row_type          row_next,
   output ips_result_type       result
);

   logic [LINE_BITS-1:0]  elapsed;
   logic [SUM_BITS:0]     sum_wide;
   logic [SUM_BITS-1:0]   sum_sat;
   logic [TALLY_BITS-1:0] tally_inc;

   always_comb begin
      // modular difference handles counter wrap
      elapsed   = line_count - row.start_mark;
      sum_wide  = {1'b0, row.accumulated} + {{(SUM_BITS + 1 - LINE_BITS){1'b0}}, elapsed};
      sum_sat   = sum_wide[SUM_BITS] ? '1 : sum_wide[SUM_BITS-1:0];
      tally_inc = (row.tally == '1) ? row.tally : row.tally + 1'b1;

      row_next = row;
      if (!row.running) begin
         row_next.running    = 1'b1;
         row_next.start_mark = line_count;
      end else begin
         row_next.running     = 1'b0;
         row_next.least       = (elapsed < row.least) ? elapsed : row.least;
         row_next.greatest    = (elapsed > row.greatest) ? elapsed : row.greatest;
         row_next.accumulated = sum_sat;
         row_next.tally       = tally_inc;
      end

      result.now_active  = row_next.running;
      result.interval    = row.running ? elapsed : '0;
      result.min_lines   = row_next.least;
      result.max_lines   = row_next.greatest;
      result.total_lines = row_next.accumulated;
      result.samples     = row_next.tally;
   end

endmodule

>>> hdl/interval_profiler_stats.sv
// Interval profiler: min / max / sum / count statistics for 16 slots.
// Input channel (req_): each transaction names a slot and carries the current
// value of the free-running 24-bit line counter. An idle slot takes the value
// as its start mark and turns active; an active slot closes the interval,
// updates its statistics and turns idle.
// Result channel (rsp_): exactly one transaction per input transaction, in
// order, carrying the new active flag, the closed interval (zero on a start)
// and the slot's minimum, maximum, saturating sum and saturating count.
// The result is registered: a transaction passes the read stage, then the result
// register. One transaction per cycle while the receiver does not stall. The
// slot state sits in a single RAM with a registered read; a read-modify-write
// writes the updated row back as the result retires, and a forwarding path covers
// back-to-back hits on a slot. Reset clears the per-slot valid bits; a slot never
// written reads as idle with empty statistics, so no clearing pass is needed.
// When the receiver stalls, the result register holds; one more transaction
// can be taken into the read stage, after which req_tready drops.
module interval_profiler_stats
   import ips_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_BYTES*8-1:0] req_tdata,  // slot[3:0], line_count[27:4]
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_BYTES*8-1:0] rsp_tdata   // now_active[0], interval[24:1],
                                              // min_lines[48:25], max_lines[72:49],
                                              // total_lines[112:73], samples[144:113]
);

   ips_request_type req;
   logic            accept;
   logic            out_free;
   logic            advance;
   logic [SLOT_BITS-1:0] req_slot;

   // read stage
   logic                 s1_valid_ff, s1_valid_in;
   logic [SLOT_BITS-1:0] s1_slot_ff, s1_slot_in;
   logic [LINE_BITS-1:0] s1_count_ff, s1_count_in;
   logic                 s1_known_ff, s1_known_in;
   logic                 fwd_hit_ff, fwd_hit_in;
   ips_row_type          fwd_row_ff, fwd_row_in;

   // per-slot written flags
   logic [SLOTS-1:0] slot_valid_ff, slot_valid_in;

   // result register
   logic           rsp_valid_ff, rsp_valid_in;
   ips_result_type rsp_result_ff, rsp_result_in;

   logic [ROW_BITS-1:0] ram_rd_data;
   ips_row_type         cur_row;
   ips_row_type         new_row;
   ips_result_type      result;

   assign req      = req_tdata[REQ_BITS-1:0];
   // slot index wraps modulo the slot count
   assign req_slot = req.slot[SLOT_BITS-1:0];

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = s1_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || out_free;
   assign accept     = req_tvalid && req_tready;

   ips_ram #(
      .WIDTH (ROW_BITS),
      .DEPTH (SLOTS)
   ) u_ips_ram (
      .clock   (clock),
      .wr_en   (advance),
      .wr_addr (s1_slot_ff),
      .wr_data (new_row),
      .rd_en   (accept),
      .rd_addr (req_slot),
      .rd_data (ram_rd_data)
   );

   // pick the freshest copy of the row: forwarded write, RAM, or reset value
   always_comb begin
      if (fwd_hit_ff) begin
         cur_row = fwd_row_ff;
      end else if (s1_known_ff) begin
         cur_row = ips_row_type'(ram_rd_data);
      end else begin
         cur_row = RESET_ROW;
      end
   end

   ips_update u_ips_update (
      .row        (cur_row),
      .line_count (s1_count_ff),
      .row_next   (new_row),
      .result     (result)
   );

   always_comb begin
      s1_valid_in   = s1_valid_ff;
      s1_slot_in    = s1_slot_ff;
      s1_count_in   = s1_count_ff;
      s1_known_in   = s1_known_ff;
      fwd_hit_in    = fwd_hit_ff;
      fwd_row_in    = fwd_row_ff;
      slot_valid_in = slot_valid_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_result_in = rsp_result_ff;

      // retire the read stage into the result register and write back
      if (advance) begin
         s1_valid_in               = 1'b0;
         slot_valid_in[s1_slot_ff] = 1'b1;
         rsp_valid_in              = 1'b1;
         rsp_result_in             = result;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      // capture a new transaction; forward the row written in this same cycle
      if (accept) begin
         s1_valid_in = 1'b1;
         s1_slot_in  = req_slot;
         s1_count_in = req.line_count;
         s1_known_in = slot_valid_ff[req_slot];
         fwd_hit_in  = advance && (s1_slot_ff == req_slot);
         fwd_row_in  = new_row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         slot_valid_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         s1_valid_ff   <= s1_valid_in;
         slot_valid_ff <= slot_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_slot_ff    <= s1_slot_in;
      s1_count_ff   <= s1_count_in;
      s1_known_ff   <= s1_known_in;
      fwd_hit_ff    <= fwd_hit_in;
      fwd_row_ff    <= fwd_row_in;
      rsp_result_ff <= rsp_result_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_BYTES*8 - RSP_BITS){1'b0}}, rsp_result_ff};

endmodule

>>> hdl/ips_checker.sv
`include "interval_profiler_stats_assert.svh"

module ips_checker
   import ips_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tready,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_BYTES*8-1:0] rsp_tdata
);

   ips_result_type rsp;
   logic           no_samples;
   logic           stats_empty;

   assign rsp         = rsp_tdata[RSP_BITS-1:0];
   assign no_samples  = (rsp.samples == '0);
   assign stats_empty = (rsp.min_lines == '1) && (rsp.max_lines == '0)
                        && (rsp.total_lines == '0);

   // nothing offered and input open straight out of reset
   `IPS_ASSERT_RST(a_idle_after_reset, reset, !rsp_tvalid && req_tready)

   // a stalled result holds
   `IPS_ASSERT_NXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

   // a start closes no interval
   `IPS_ASSERT_IMP(a_start_zero, rsp_tvalid && rsp.now_active, rsp.interval == '0)

   // empty statistics until the first sample
   `IPS_ASSERT_IMP(a_empty_stats, rsp_tvalid && no_samples, stats_empty)

   // ordered extremes once a sample exists
   `IPS_ASSERT_IMP(a_ordered_stats, rsp_tvalid && !no_samples, rsp.min_lines <= rsp.max_lines)

endmodule

bind interval_profiler_stats ips_checker u_ips_checker (.*);

>>> tb/tb_interval_profiler_stats.sv
`timescale 1ns / 1ps

module tb_interval_profiler_stats
   import ips_pkg::*;
();

   localparam int DRAIN_LIMIT = 20000;
   localparam bit [SUM_BITS-1:0]   SUM_FULL   = '1;
   localparam bit [TALLY_BITS-1:0] TALLY_FULL = '1;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_BYTES*8-1:0] req_tdata  = '0;  // slot[3:0], line_count[27:4]
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_BYTES*8-1:0] rsp_tdata;        // now_active, interval, min_lines,
                                             // max_lines, total_lines, samples

   // mirror of the per-slot profiling state
   bit                  slot_running  [SLOTS];
   bit [LINE_BITS-1:0]  slot_start    [SLOTS];
   bit [LINE_BITS-1:0]  slot_least    [SLOTS];
   bit [LINE_BITS-1:0]  slot_greatest [SLOTS];
   bit [SUM_BITS-1:0]   slot_sum      [SLOTS];
   bit [TALLY_BITS-1:0] slot_tally    [SLOTS];

   ips_result_type pending_results[$];

   int error_count     = 0;
   int send_gap_pct    = 0;
   int recv_stall_pct  = 0;
   int rsp_hold_cycles = 0;
   logic [SLOT_FIELD-1:0] recent_slot = '0;
   logic [LINE_BITS-1:0]  line_clock  = '0;

   interval_profiler_stats u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Hard stop in case a handshake never completes.
   initial begin
      #6_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      error_count++;
      if (error_count <= 100)
         $display("ERROR %0t: %s got %0h expected %0h", $realtime, what, got, want);
   endtask

   function automatic void clear_profile();
      for (int i = 0; i < SLOTS; i++) begin
         slot_running[i]  = 1'b0;
         slot_start[i]    = '0;
         slot_least[i]    = '1;
         slot_greatest[i] = '0;
         slot_sum[i]      = '0;
         slot_tally[i]    = '0;
      end
   endfunction

   // Apply one start/stop event to the mirror and return the result it yields.
   function automatic ips_result_type profile_update(input logic [SLOT_FIELD-1:0] slot,
                                                     input logic [LINE_BITS-1:0]  now);
      int unsigned        s;
      bit [LINE_BITS-1:0] span;
      ips_result_type     res;
      s    = slot % SLOTS;
      span = '0;
      if (!slot_running[s]) begin
         slot_start[s]   = now;
         slot_running[s] = 1'b1;
      end else begin
         span = now - slot_start[s];   // wraps modulo 2^24
         if (span < slot_least[s])
            slot_least[s] = span;
         if (span > slot_greatest[s])
            slot_greatest[s] = span;
         if (slot_sum[s] > SUM_FULL - span)
            slot_sum[s] = SUM_FULL;
         else
            slot_sum[s] = slot_sum[s] + span;
         if (slot_tally[s] != TALLY_FULL)
            slot_tally[s] = slot_tally[s] + 1'b1;
         slot_running[s] = 1'b0;
      end
      res.now_active  = slot_running[s];
      res.interval    = span;
      res.min_lines   = slot_least[s];
      res.max_lines   = slot_greatest[s];
      res.total_lines = slot_sum[s];
      res.samples     = slot_tally[s];
      return res;
   endfunction

   // Predict on every accepted request, compare every accepted result.
   always @(posedge clock) begin
      ips_request_type req;
      ips_result_type  got;
      ips_result_type  want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            req = req_tdata[REQ_BITS-1:0];
            pending_results.push_back(profile_update(req.slot, req.line_count));
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[RSP_BITS-1:0];
            if (pending_results.size() == 0) begin
               report_mismatch("unexpected result", got.interval, 0);
            end else begin
               want = pending_results.pop_front();
               if (got.now_active !== want.now_active)
                  report_mismatch("now_active", got.now_active, want.now_active);
               if (got.interval !== want.interval)
                  report_mismatch("interval", got.interval, want.interval);
               if (got.min_lines !== want.min_lines)
                  report_mismatch("min_lines", got.min_lines, want.min_lines);
               if (got.max_lines !== want.max_lines)
                  report_mismatch("max_lines", got.max_lines, want.max_lines);
               if (got.total_lines !== want.total_lines)
                  report_mismatch("total_lines", got.total_lines, want.total_lines);
               if (got.samples !== want.samples)
                  report_mismatch("samples", got.samples, want.samples);
            end
            if (rsp_tdata[RSP_BYTES*8-1:RSP_BITS] !== '0)
               report_mismatch("padding", rsp_tdata[RSP_BYTES*8-1:RSP_BITS], 0);
         end
      end
   end

   // Receiver: a long hold-off when asked for, otherwise random stalls.
   always @(posedge clock) begin
      if (rsp_hold_cycles > 0) begin
         rsp_hold_cycles = rsp_hold_cycles - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Offer one request and return at the edge that accepts it; tvalid stays up.
   task automatic send_request(input logic [SLOT_FIELD-1:0] slot,
                               input logic [LINE_BITS-1:0]  now);
      ips_request_type        item;
      logic [REQ_BYTES*8-1:0] word;
      item.slot       = slot;
      item.line_count = now;
      word            = '0;
      word[REQ_BITS-1:0] = item;
      while ($urandom_range(99) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      do @(posedge clock); while (!req_tready);
      recent_slot = slot;
   endtask

   task automatic stop_sending();
      req_tvalid <= 1'b0;
   endtask

   // Hold until every predicted result has come back, then let the pipe settle.
   task automatic await_results();
      int waited;
      waited = 0;
      while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (pending_results.size() != 0) begin
         report_mismatch("results never delivered", pending_results.size(), 0);
         pending_results.delete();
      end
      repeat (4) @(posedge clock);
   endtask

   function automatic logic [LINE_BITS-1:0] pick_line_count();
      case ($urandom_range(7))
         0: return '0;
         1: return {LINE_BITS{1'b1}};
         2: return LINE_BITS'($urandom_range(255));
         3: return {LINE_BITS{1'b1}} - LINE_BITS'($urandom_range(255));
         4, 5: begin
            // advance a free-running line counter, as real traffic would
            line_clock = line_clock + LINE_BITS'($urandom_range(4000));
            return line_clock;
         end
         default: return LINE_BITS'($urandom);
      endcase
   endfunction

   // Favour the last slot so back-to-back hits on one slot are frequent.
   function automatic logic [SLOT_FIELD-1:0] pick_slot();
      if ($urandom_range(1) == 0)
         return recent_slot;
      return SLOT_FIELD'($urandom_range(SLOTS - 1));
   endfunction

   // Zero interval, counter wrap, full-range interval and back-to-back hits.
   task automatic test_directed_cases();
      send_gap_pct   = 0;
      recv_stall_pct = 0;
      send_request(4'd0,  24'h000000);   // first start
      send_request(4'd0,  24'h000000);   // zero interval becomes the minimum
      send_request(4'd1,  24'hFFFFF0);
      send_request(4'd1,  24'h000010);   // wrap through zero
      send_request(4'd2,  24'h000000);
      send_request(4'd2,  24'hFFFFFF);   // largest interval
      send_request(4'd3,  24'h000001);
      send_request(4'd3,  24'h000000);   // wrap to the largest interval
      send_request(4'd15, 24'h123456);
      send_request(4'd15, 24'h123457);
      send_request(4'd15, 24'h654321);
      send_request(4'd15, 24'h654300);   // large wrapped interval, new maximum
      send_request(4'd15, 24'h654300);
      send_request(4'd15, 24'h654300);   // zero interval after non-zero ones
      send_request(4'd4,  24'hAAAAAA);
      send_request(4'd5,  24'h555555);
      send_request(4'd4,  24'h555555);
      send_request(4'd5,  24'hAAAAAA);
      send_request(4'd8,  24'h800000);
      send_request(4'd8,  24'h7FFFFF);
      stop_sending();
      await_results();
   endtask

   task automatic test_random_traffic(input int count, input int send_pct,
                                      input int recv_pct);
      send_gap_pct   = send_pct;
      recv_stall_pct = recv_pct;
      for (int i = 0; i < count; i++)
         send_request(pick_slot(), pick_line_count());
      stop_sending();
      await_results();
   endtask

   // Hold off the receiver for a long stretch while requests keep coming,
   // so the block fills and drops req_tready.
   task automatic test_receiver_backpressure();
      send_gap_pct    = 0;
      recv_stall_pct  = 0;
      rsp_hold_cycles = 150;
      for (int i = 0; i < 40; i++)
         send_request(pick_slot(), pick_line_count());
      stop_sending();
      await_results();
   endtask

   initial begin
      clear_profile();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_cases();
      test_random_traffic(230, 35, 68);
      test_receiver_backpressure();
      test_random_traffic(230, 68, 35);
      test_random_traffic(230, 0, 0);

      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
